@@ rtl/aaq_pkg.sv @@
// Shared constants, types and the arctangent table of the axis-angle to quaternion block.
// Used by every other file in rtl; depends on nothing.
package aaq_pkg;

    localparam int FIELD_W = 16;   // width of every payload field
    localparam int THETA_W = 36;   // signed angle with 32 fraction bits
    localparam int SUM_W   = 32;   // x^2 + y^2 + z^2
    localparam int LEN_W   = 32;   // axis length with 16 fraction bits
    localparam int REM_W   = 34;   // square root remainder
    localparam int SQ_N    = 32;   // one root bit per square root cell
    localparam int SMAG_W  = 32;   // sine magnitude with 30 fraction bits
    localparam int NUM_W   = 48;   // dividend width
    localparam int QB_N    = 14;   // quotient bits below the saturation point
    localparam int ATAN_N  = 24;

    localparam logic signed [THETA_W-1:0] HALF_PI_Q32 = 36'sd6746518852;
    localparam logic signed [THETA_W-1:0] PI_Q32      = 36'sd13493037705;
    localparam logic [63:0]               GAIN_Q32    = 64'd2608131497;
    localparam logic [FIELD_W-2:0]        Q14_MAX     = 15'd16384;

    typedef struct packed {
        logic [FIELD_W-1:0] amag_x;
        logic [FIELD_W-1:0] amag_y;
        logic [FIELD_W-1:0] amag_z;
        logic [2:0]         ax_neg;
        logic               zero;
        logic               flip;
    } t_front_sb;

    typedef struct packed {
        logic [FIELD_W-1:0] cw;
        logic [2:0]         out_neg;
        logic [2:0]         ovf;
        logic               zero;
    } t_back_sb;

    // atan(2^-i) with 32 fraction bits.
    function automatic logic [THETA_W-1:0] f_atan(input int unsigned idx);
        logic [THETA_W-1:0] v;
        case (idx)
            0:  v = 36'd3373259426;
            1:  v = 36'd1991351318;
            2:  v = 36'd1052175346;
            3:  v = 36'd534100635;
            4:  v = 36'd268086748;
            5:  v = 36'd134174063;
            6:  v = 36'd67103403;
            7:  v = 36'd33553749;
            8:  v = 36'd16777131;
            9:  v = 36'd8388597;
            10: v = 36'd4194303;
            11: v = 36'd2097152;
            12: v = 36'd1048576;
            13: v = 36'd524288;
            14: v = 36'd262144;
            15: v = 36'd131072;
            16: v = 36'd65536;
            17: v = 36'd32768;
            18: v = 36'd16384;
            19: v = 36'd8192;
            20: v = 36'd4096;
            21: v = 36'd2048;
            22: v = 36'd1024;
            23: v = 36'd512;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/aaq_if.sv @@
// Valid/ready stream interfaces for the axis-angle input and the quaternion output.
// Depends on aaq_pkg for the field width.
interface aaq_in_if;
    import aaq_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  axis_x;
    logic signed [FIELD_W-1:0]  axis_y;
    logic signed [FIELD_W-1:0]  axis_z;
    logic signed [FIELD_W-1:0]  angle;
    modport source (output valid, axis_x, axis_y, axis_z, angle, input ready);
    modport sink   (input valid, axis_x, axis_y, axis_z, angle, output ready);
endinterface

interface aaq_out_if;
    import aaq_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  quat_w;
    logic signed [FIELD_W-1:0]  quat_x;
    logic signed [FIELD_W-1:0]  quat_y;
    logic signed [FIELD_W-1:0]  quat_z;
    logic                       zero_axis;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, zero_axis, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, zero_axis, output ready);
endinterface

@@ rtl/aaq_cordic_cell.sv @@
// One rotation-mode CORDIC stage with its own output register.
// Depends on aaq_pkg for the arctangent table.
module aaq_cordic_cell import aaq_pkg::*; #(
    parameter int DW    = 16,
    parameter int STAGE = 0
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [DW+2:0]      i_x,
    input  logic signed [DW+2:0]      i_y,
    input  logic signed [THETA_W-1:0] i_z,
    output logic signed [DW+2:0]      o_x,
    output logic signed [DW+2:0]      o_y,
    output logic signed [THETA_W-1:0] o_z
);
    localparam logic signed [THETA_W-1:0] ATAN = signed'(f_atan(STAGE));

    logic signed [DW+2:0] dx, dy;
    logic signed [DW+2:0] r_x, r_y;
    logic signed [THETA_W-1:0] r_z;

    assign dx = i_y >>> STAGE;
    assign dy = i_x >>> STAGE;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[THETA_W-1]) begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_z <= i_z + ATAN;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

@@ rtl/aaq_sqrt_cell.sv @@
// One bit of the digit-by-digit integer square root of the squared length times 2^32.
// Depends on aaq_pkg for widths.
module aaq_sqrt_cell import aaq_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SUM_W-1:0]   i_sum,
    input  logic [REM_W-1:0]   i_rem,
    input  logic [LEN_W-1:0]   i_root,
    output logic [SUM_W-1:0]   o_sum,
    output logic [REM_W-1:0]   o_rem,
    output logic [LEN_W-1:0]   o_root
);
    logic [1:0]       pair;
    logic [REM_W+1:0] remx, trial;
    logic             ge;
    logic [SUM_W-1:0] r_sum;
    logic [REM_W-1:0] r_rem;
    logic [LEN_W-1:0] r_root;

    // The low half of the radicand is all zeros.
    generate
        if (IDX < SUM_W / 2) begin : g_hi
            assign pair = i_sum[SUM_W-1-2*IDX -: 2];
        end else begin : g_lo
            assign pair = 2'b00;
        end
    endgenerate

    assign remx  = {i_rem, pair};
    assign trial = {2'b00, i_root, 2'b01};
    assign ge    = (remx >= trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= i_sum;
            r_rem  <= ge ? REM_W'(remx - trial) : REM_W'(remx);
            r_root <= {i_root[LEN_W-2:0], ge};
        end
    end

    assign o_sum  = r_sum;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

@@ rtl/aaq_div_cell.sv @@
// One quotient bit of a restoring divide, for one vector lane.
// Depends on aaq_pkg for widths.
module aaq_div_cell import aaq_pkg::*; #(
    parameter int SH = 0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [NUM_W-1:0]   i_rem,
    input  logic [QB_N-1:0]    i_q,
    input  logic [LEN_W-1:0]   i_d,
    output logic [NUM_W-1:0]   o_rem,
    output logic [QB_N-1:0]    o_q,
    output logic [LEN_W-1:0]   o_d
);
    logic [NUM_W-1:0] dsh;
    logic             ge;
    logic [QB_N-1:0]  n_q;
    logic [NUM_W-1:0] r_rem;
    logic [QB_N-1:0]  r_q;
    logic [LEN_W-1:0] r_d;

    assign dsh = NUM_W'(i_d) << SH;
    assign ge  = (i_rem >= dsh);

    always_comb begin
        n_q     = i_q;
        n_q[SH] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= ge ? i_rem - dsh : i_rem;
            r_q   <= n_q;
            r_d   <= i_d;
        end
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;
    assign o_d   = r_d;
endmodule

@@ rtl/axis_angle_to_quaternion.sv @@
// Top level of the axis-angle to quaternion block: front stage, CORDIC and square root
// cell rows, product stage, divider cell rows and output register. Depends on aaq_pkg,
// aaq_if and the three cell modules.
//
// Usage. Input beats on i_in carry an axis (three signed integers of any common scale)
// and an angle in radians as signed Q3.12. Each input beat yields exactly one output
// beat on o_out: quat_w = cos(angle/2) and quat_x/y/z = axis * sin(angle/2) / |axis|,
// all signed Q1.14 and limited to +-16384. An all-zero axis sets zero_axis and drives
// the vector parts to zero, while quat_w still carries the cosine.
//
// Timing. The block is one pipeline of 50 register stages: a front stage, 32 square
// root cells (one root bit each) beside CORDIC_STAGES (at most 24) CORDIC cells padded
// to the same depth, a product stage, a saturation check stage, 14 divider cells per
// vector lane and the output register. The accepting edge loads the front stage.
// One beat is accepted every cycle while the receiver does not stall; the square root
// row, one bit per cell, sets the depth. Reset clears every valid bit, so no beat is
// presented after reset until new input arrives. When the receiver stalls with a beat
// waiting, the whole pipeline holds and i_in.ready drops in the same cycle; nothing is
// lost or repeated.
module axis_angle_to_quaternion import aaq_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int DATA_WIDTH    = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aaq_in_if.sink     i_in,
    aaq_out_if.source  o_out
);
    localparam int DW   = DATA_WIDTH;
    localparam int XW   = DW + 3;
    localparam int CS   = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
    localparam int PAD  = SQ_N - CS;
    localparam int KS   = 32 - DW;
    localparam logic [63:0] K_FULL =
        (KS == 0) ? GAIN_Q32 : ((GAIN_Q32 + (64'd1 << ((KS == 0) ? 0 : KS - 1))) >> KS);
    localparam logic signed [XW-1:0] X0 = signed'(K_FULL[XW-1:0]);
    // Requantization of the cosine to 14 and the sine to 30 fraction bits.
    localparam int D14  = (DW > 14) ? DW - 14 : 0;
    localparam int D14R = (DW > 14) ? DW - 15 : 0;
    localparam int L14  = (DW < 14) ? 14 - DW : 0;
    localparam logic [XW+1:0] RND14 = (DW > 14) ? (XW + 2)'(1) << D14R : '0;
    localparam int D30  = (DW > 30) ? DW - 30 : 0;
    localparam int D30R = (DW > 30) ? DW - 31 : 0;
    localparam int L30  = (DW <= 30) ? 30 - DW : 0;
    localparam logic [XW+17:0] RND30 = (DW > 30) ? (XW + 18)'(1) << D30R : '0;

    // The pipeline advances whenever the output register is free or being emptied.
    logic en;
    logic r_ovalid;
    assign en         = !r_ovalid || o_out.ready;
    assign i_in.ready = en;

    // ---------------- front stage ----------------
    logic signed [THETA_W-1:0] theta_raw, n_theta;
    logic                      n_flip;
    logic [FIELD_W-1:0]        n_amag [3];
    logic signed [2*FIELD_W-1:0] sq [3];
    logic [SUM_W-1:0]          n_sum;
    logic signed [FIELD_W-1:0] ax [3];

    assign ax[0] = i_in.axis_x;
    assign ax[1] = i_in.axis_y;
    assign ax[2] = i_in.axis_z;
    // angle * 2^20 / 2 puts the half angle at 32 fraction bits.
    assign theta_raw = {i_in.angle[FIELD_W-1], i_in.angle, 19'b0};

    always_comb begin
        n_theta = theta_raw;
        n_flip  = 1'b0;
        if (theta_raw > HALF_PI_Q32) begin
            n_theta = theta_raw - PI_Q32;
            n_flip  = 1'b1;
        end else if (theta_raw < -HALF_PI_Q32) begin
            n_theta = theta_raw + PI_Q32;
            n_flip  = 1'b1;
        end
        for (int k = 0; k < 3; k++) begin
            n_amag[k] = ax[k][FIELD_W-1] ? FIELD_W'(-ax[k]) : FIELD_W'(ax[k]);
            sq[k]     = ax[k] * ax[k];
        end
        n_sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    end

    logic                      r_v1 [SQ_N+1];
    t_front_sb                 r_sb1 [SQ_N+1];
    logic signed [THETA_W-1:0] r_theta;
    logic [SUM_W-1:0]          r_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_theta          <= n_theta;
            r_sum            <= n_sum;
            r_sb1[0].amag_x  <= n_amag[0];
            r_sb1[0].amag_y  <= n_amag[1];
            r_sb1[0].amag_z  <= n_amag[2];
            r_sb1[0].ax_neg  <= {ax[2][FIELD_W-1], ax[1][FIELD_W-1], ax[0][FIELD_W-1]};
            r_sb1[0].zero    <= (n_sum == '0);
            r_sb1[0].flip    <= n_flip;
            for (int s = 1; s <= SQ_N; s++) begin
                r_sb1[s] <= r_sb1[s-1];
            end
        end
    end

    // ---------------- CORDIC row, padded to the square root depth ----------------
    logic signed [XW-1:0]      cx [CS+1];
    logic signed [XW-1:0]      cy [CS+1];
    logic signed [THETA_W-1:0] cz [CS+1];
    assign cx[0] = X0;
    assign cy[0] = '0;
    assign cz[0] = r_theta;

    generate
        for (genvar g = 0; g < CS; g++) begin : g_cordic
            aaq_cordic_cell #(.DW(DW), .STAGE(g)) u_cell (
                .i_clk (i_clk), .i_en (en),
                .i_x (cx[g]), .i_y (cy[g]), .i_z (cz[g]),
                .o_x (cx[g+1]), .o_y (cy[g+1]), .o_z (cz[g+1])
            );
        end
    endgenerate

    logic signed [XW-1:0] r_px [PAD];
    logic signed [XW-1:0] r_py [PAD];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px[0] <= cx[CS];
            r_py[0] <= cy[CS];
            for (int p = 1; p < PAD; p++) begin
                r_px[p] <= r_px[p-1];
                r_py[p] <= r_py[p-1];
            end
        end
    end

    // ---------------- square root row ----------------
    logic [SUM_W-1:0] qs [SQ_N+1];
    logic [REM_W-1:0] qr [SQ_N+1];
    logic [LEN_W-1:0] qt [SQ_N+1];
    assign qs[0] = r_sum;
    assign qr[0] = '0;
    assign qt[0] = '0;

    generate
        for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
            aaq_sqrt_cell #(.IDX(g)) u_cell (
                .i_clk (i_clk), .i_en (en),
                .i_sum (qs[g]), .i_rem (qr[g]), .i_root (qt[g]),
                .o_sum (qs[g+1]), .o_rem (qr[g+1]), .o_root (qt[g+1])
            );
        end
    endgenerate

    // ---------------- product stage ----------------
    logic signed [XW-1:0] fx, fy;
    logic [XW-1:0]        xa, ya;
    logic                 x_neg, y_neg;
    logic [XW+1:0]        cwm;
    logic [FIELD_W-2:0]   cmag;
    logic [XW+17:0]       sm;
    logic [SMAG_W-1:0]    smag;
    logic [FIELD_W-1:0]   amag [3];
    logic [FIELD_W-1:0]   n_cw;
    logic [NUM_W-1:0]     n_num [3];
    logic [LEN_W-1:0]     len;

    assign fx   = r_px[PAD-1];
    assign fy   = r_py[PAD-1];
    assign len  = qt[SQ_N];
    assign amag[0] = r_sb1[SQ_N].amag_x;
    assign amag[1] = r_sb1[SQ_N].amag_y;
    assign amag[2] = r_sb1[SQ_N].amag_z;

    always_comb begin
        xa    = fx[XW-1] ? XW'(-fx) : XW'(fx);
        ya    = fy[XW-1] ? XW'(-fy) : XW'(fy);
        // A reduced angle negates both results.
        x_neg = fx[XW-1] ^ r_sb1[SQ_N].flip;
        y_neg = fy[XW-1] ^ r_sb1[SQ_N].flip;
        if (DW > 14) begin
            cwm = ({2'b00, xa} + RND14) >> D14;
        end else begin
            cwm = {2'b00, xa} << L14;
        end
        cmag = (cwm > (XW + 2)'(Q14_MAX)) ? Q14_MAX : cwm[FIELD_W-2:0];
        n_cw = x_neg ? FIELD_W'(-{1'b0, cmag}) : {1'b0, cmag};
        if (DW <= 30) begin
            sm = {18'b0, ya} << L30;
        end else begin
            sm = ({18'b0, ya} + RND30) >> D30;
        end
        smag = sm[SMAG_W-1:0];
        for (int k = 0; k < 3; k++) begin
            n_num[k] = NUM_W'(amag[k]) * NUM_W'(smag) + NUM_W'(len >> 1);
        end
    end

    logic             r_vm;
    logic [NUM_W-1:0] r_num [3];
    logic [LEN_W-1:0] r_len;
    logic [FIELD_W-1:0] r_cw;
    logic [2:0]       r_oneg;
    logic             r_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num  <= n_num;
            r_len  <= len;
            r_cw   <= n_cw;
            r_oneg <= r_sb1[SQ_N].ax_neg ^ {3{y_neg}};
            r_zero <= r_sb1[SQ_N].zero;
        end
    end

    // ---------------- saturation check ----------------
    // A quotient of 16384 or more saturates, so the divider needs only 14 bits.
    logic [NUM_W-1:0] lim;
    logic [2:0]       n_ovf;
    assign lim = NUM_W'(r_len) << QB_N;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ovf[k] = (r_num[k] >= lim);
        end
    end

    logic             r_v2 [QB_N+1];
    t_back_sb         r_sb2 [QB_N+1];
    logic [NUM_W-1:0] r_drem [3];
    logic [LEN_W-1:0] r_dlen;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_drem          <= r_num;
            r_dlen          <= r_len;
            r_sb2[0].cw      <= r_cw;
            r_sb2[0].out_neg <= r_oneg;
            r_sb2[0].ovf     <= n_ovf;
            r_sb2[0].zero    <= r_zero;
            for (int s = 1; s <= QB_N; s++) begin
                r_sb2[s] <= r_sb2[s-1];
            end
        end
    end

    // ---------------- divider rows, one per vector lane ----------------
    logic [NUM_W-1:0] dr [3][QB_N+1];
    logic [QB_N-1:0]  dq [3][QB_N+1];
    logic [LEN_W-1:0] dd [3][QB_N+1];

    generate
        for (genvar l = 0; l < 3; l++) begin : g_lane
            assign dr[l][0] = r_drem[l];
            assign dq[l][0] = '0;
            assign dd[l][0] = r_dlen;
            for (genvar g = 0; g < QB_N; g++) begin : g_div
                aaq_div_cell #(.SH(QB_N - 1 - g)) u_cell (
                    .i_clk (i_clk), .i_en (en),
                    .i_rem (dr[l][g]), .i_q (dq[l][g]), .i_d (dd[l][g]),
                    .o_rem (dr[l][g+1]), .o_q (dq[l][g+1]), .o_d (dd[l][g+1])
                );
            end
        end
    endgenerate

    // ---------------- output register ----------------
    logic [FIELD_W-2:0] vmag [3];
    logic [FIELD_W-1:0] n_vec [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vmag[k] = r_sb2[QB_N].ovf[k] ? Q14_MAX : {1'b0, dq[k][QB_N]};
            if (r_sb2[QB_N].zero) begin
                n_vec[k] = '0;
            end else if (r_sb2[QB_N].out_neg[k]) begin
                n_vec[k] = FIELD_W'(-{1'b0, vmag[k]});
            end else begin
                n_vec[k] = {1'b0, vmag[k]};
            end
        end
    end

    logic signed [FIELD_W-1:0] r_qw, r_qx, r_qy, r_qz;
    logic                      r_qzero;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qw    <= signed'(r_sb2[QB_N].cw);
            r_qx    <= signed'(n_vec[0]);
            r_qy    <= signed'(n_vec[1]);
            r_qz    <= signed'(n_vec[2]);
            r_qzero <= r_sb2[QB_N].zero;
        end
    end

    // Valid bits are the only state that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= SQ_N; s++) r_v1[s] <= 1'b0;
            r_vm <= 1'b0;
            for (int s = 0; s <= QB_N; s++) r_v2[s] <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_v1[0] <= i_in.valid;
            for (int s = 1; s <= SQ_N; s++) r_v1[s] <= r_v1[s-1];
            r_vm    <= r_v1[SQ_N];
            r_v2[0] <= r_vm;
            for (int s = 1; s <= QB_N; s++) r_v2[s] <= r_v2[s-1];
            r_ovalid <= r_v2[QB_N];
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.quat_w    = r_qw;
    assign o_out.quat_x    = r_qx;
    assign o_out.quat_y    = r_qy;
    assign o_out.quat_z    = r_qz;
    assign o_out.zero_axis = r_qzero;

    // ---------------- assertions ----------------
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_qzero) |-> (r_qx == '0 && r_qy == '0 && r_qz == '0))
        else $error("zero axis with nonzero vector part");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en) |=> ($stable(r_v2[QB_N]) && $stable(r_vm) && $stable(r_v1[SQ_N])))
        else $error("pipeline moved during a stall");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_qw <= 16'sd16384 && r_qw >= -16'sd16384))
        else $error("quat_w out of range");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> (r_ovalid && $stable(r_qx) && $stable(r_qw)))
        else $error("output beat changed while stalled");
endmodule
